>>> rtl/tdr_pkg.sv
// Package for the TFTP data receiver: sizes, protocol codes and the
// queue entry passed from the front (parser) to the back (result issue).
// No dependencies.
`default_nettype none

package tdr_pkg;

    localparam int BLOCK_SIZE  = 512;
    localparam int MAX_DATA    = 1024;
    localparam int COUNT_W     = $clog2(MAX_DATA + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] OPCODE_DATA = 16'd3;
    localparam logic [2:0]  HDR_LEN     = 3'd4;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_ACK   = 1'b1;

    typedef struct packed {
        logic        has_write;
        logic        has_ack;
        logic [31:0] write_address;
        logic [7:0]  write_data;
        logic [15:0] ack_block;
        logic [15:0] ack_port;
        logic        transfer_done;
    } tdr_entry_t;

endpackage

`default_nettype wire

>>> rtl/tdr_front.sv
// Front end: parses TFTP header bytes, tracks the expected block and
// builds queue entries (data write and/or ack). Depends on tdr_pkg.
`default_nettype none

module tdr_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    input  wire logic [31:0]         cfg_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_payload_byte,
    input  wire logic                s_packet_end,
    input  wire logic [15:0]         s_sender_port,
    output logic                     push_valid,
    output tdr_pkg::tdr_entry_t      push_entry,
    input  wire logic                push_ready
);

    localparam logic [31:0] BLOCK_SIZE_32 = 32'(tdr_pkg::BLOCK_SIZE);
    localparam logic [tdr_pkg::COUNT_W-1:0] MAX_CNT =
        tdr_pkg::COUNT_W'(tdr_pkg::MAX_DATA);
    localparam logic [tdr_pkg::COUNT_W-1:0] BLK_CNT =
        tdr_pkg::COUNT_W'(tdr_pkg::BLOCK_SIZE);

    logic [31:0]                  base_reg;
    logic [2:0]                   hdr_pos_reg, hdr_pos_next;
    logic [15:0]                  opcode_reg, opcode_next;
    logic [15:0]                  block_reg, block_next;
    logic [15:0]                  exp_block_reg, exp_block_next;
    logic [tdr_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [31:0]                  blk_off_reg;
    logic [31:0]                  block_addr_reg;

    logic                         in_xfer;
    logic                         in_header;
    logic                         match;
    logic                         do_write;
    logic                         do_ack;
    logic                         short_block;
    logic [tdr_pkg::COUNT_W-1:0]  count_upd;
    logic [2:0]                   hdr_pos_upd;
    logic [15:0]                  opcode_upd;
    logic [15:0]                  block_upd;
    logic [31:0]                  exp_m1;

    assign s_ready = push_ready;
    assign in_xfer = s_valid && s_ready;

    // (expected_block - 1) modulo 2^32; block 0 lies one block below base
    assign exp_m1 = {{16{exp_block_reg == 16'd0}}, exp_block_reg - 16'd1};

    always_comb begin
        in_header   = hdr_pos_reg < tdr_pkg::HDR_LEN;
        hdr_pos_upd = hdr_pos_reg;
        opcode_upd  = opcode_reg;
        block_upd   = block_reg;
        if (in_header) begin
            hdr_pos_upd = hdr_pos_reg + 3'd1;
            if (hdr_pos_reg < 3'd2) begin
                opcode_upd = {opcode_reg[7:0], s_payload_byte};
            end else begin
                block_upd = {block_reg[7:0], s_payload_byte};
            end
        end
        match       = (opcode_reg == tdr_pkg::OPCODE_DATA) && (block_reg == exp_block_reg);
        do_write    = !in_header && match && (count_reg < MAX_CNT);
        count_upd   = count_reg + tdr_pkg::COUNT_W'(do_write);
        // header may complete on the final byte itself (empty data block)
        do_ack      = s_packet_end && (hdr_pos_upd == tdr_pkg::HDR_LEN)
                      && (opcode_upd == tdr_pkg::OPCODE_DATA)
                      && (block_upd == exp_block_reg);
        short_block = count_upd < BLK_CNT;

        hdr_pos_next   = hdr_pos_reg;
        opcode_next    = opcode_reg;
        block_next     = block_reg;
        count_next     = count_reg;
        exp_block_next = exp_block_reg;

        if (in_xfer) begin
            hdr_pos_next = hdr_pos_upd;
            opcode_next  = opcode_upd;
            block_next   = block_upd;
            count_next   = count_upd;
            if (do_ack) begin
                exp_block_next = short_block ? 16'd1 : exp_block_reg + 16'd1;
            end
            if (s_packet_end) begin
                hdr_pos_next = 3'd0;
                opcode_next  = 16'd0;
                block_next   = 16'd0;
                count_next   = '0;
            end
        end
    end

    always_comb begin
        push_valid                 = in_xfer && (do_write || do_ack);
        push_entry.has_write       = do_write;
        push_entry.has_ack         = do_ack;
        push_entry.write_address   = block_addr_reg + 32'(count_reg);
        push_entry.write_data      = s_payload_byte;
        push_entry.ack_block       = block_upd;
        push_entry.ack_port        = s_sender_port;
        push_entry.transfer_done   = short_block;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= 32'd0;
            hdr_pos_reg   <= 3'd0;
            opcode_reg    <= 16'd0;
            block_reg     <= 16'd0;
            exp_block_reg <= 16'd1;
            count_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                base_reg <= cfg_data;
            end
            hdr_pos_reg   <= hdr_pos_next;
            opcode_reg    <= opcode_next;
            block_reg     <= block_next;
            exp_block_reg <= exp_block_next;
            count_reg     <= count_next;
        end
    end

    // block start address, two stages; settles within the four header bytes
    always_ff @(posedge aclk) begin
        blk_off_reg    <= exp_m1 * BLOCK_SIZE_32;
        block_addr_reg <= base_reg + blk_off_reg;
    end

endmodule

`default_nettype wire

>>> rtl/tdr_queue.sv
// Small FIFO of entries between the parser and the result issue stage.
// Depends on tdr_pkg.
`default_nettype none

module tdr_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push_valid,
    input  wire tdr_pkg::tdr_entry_t push_entry,
    output logic                     push_ready,
    output logic                     pop_valid,
    output tdr_pkg::tdr_entry_t      pop_entry,
    input  wire logic                pop
);

    tdr_pkg::tdr_entry_t               mem_reg [tdr_pkg::QUEUE_DEPTH];
    logic [tdr_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [tdr_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [tdr_pkg::QCNT_W-1:0]        cnt_reg, cnt_next;
    logic                              do_push;
    logic                              do_pop;

    assign push_ready = cnt_reg != tdr_pkg::QCNT_W'(tdr_pkg::QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + tdr_pkg::QCNT_W'(do_push) - tdr_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tdr_back.sv
// Result issue: splits each queue entry into a write and/or an ack
// transfer and holds them in the output register. Depends on tdr_pkg.
`default_nettype none

module tdr_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                pop_valid,
    input  wire tdr_pkg::tdr_entry_t pop_entry,
    output logic                     pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_kind,
    output logic [31:0]              m_write_address,
    output logic [7:0]               m_write_data,
    output logic [15:0]              m_ack_block,
    output logic [15:0]              m_ack_port,
    output logic                     m_transfer_done,
    output logic                     m_final_result
);

    logic        valid_reg, valid_next;
    logic        ack_phase_reg, ack_phase_next;
    logic        kind_reg, kind_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  data_reg, data_next;
    logic [15:0] blk_reg, blk_next;
    logic [15:0] port_reg, port_next;
    logic        done_reg, done_next;
    logic        final_reg, final_next;
    logic        out_free;
    logic        load;
    logic        emit_write;

    assign out_free   = !valid_reg || m_ready;
    assign load       = out_free && pop_valid;
    assign emit_write = pop_entry.has_write && !ack_phase_reg;

    always_comb begin
        valid_next     = valid_reg;
        ack_phase_next = ack_phase_reg;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        blk_next       = blk_reg;
        port_next      = port_reg;
        done_next      = done_reg;
        final_next     = final_reg;
        pop            = 1'b0;

        if (out_free) begin
            valid_next = pop_valid;
        end
        if (load) begin
            if (emit_write) begin
                kind_next      = tdr_pkg::KIND_WRITE;
                addr_next      = pop_entry.write_address;
                data_next      = pop_entry.write_data;
                blk_next       = 16'd0;
                port_next      = 16'd0;
                done_next      = 1'b0;
                final_next     = !pop_entry.has_ack;
                pop            = !pop_entry.has_ack;
                ack_phase_next = pop_entry.has_ack;
            end else begin
                kind_next      = tdr_pkg::KIND_ACK;
                addr_next      = 32'd0;
                data_next      = 8'd0;
                blk_next       = pop_entry.ack_block;
                port_next      = pop_entry.ack_port;
                done_next      = pop_entry.transfer_done;
                final_next     = 1'b1;
                pop            = 1'b1;
                ack_phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            ack_phase_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            ack_phase_reg <= ack_phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        addr_reg  <= addr_next;
        data_reg  <= data_next;
        blk_reg   <= blk_next;
        port_reg  <= port_next;
        done_reg  <= done_next;
        final_reg <= final_next;
    end

    assign m_valid         = valid_reg;
    assign m_kind          = kind_reg;
    assign m_write_address = addr_reg;
    assign m_write_data    = data_reg;
    assign m_ack_block     = blk_reg;
    assign m_ack_port      = port_reg;
    assign m_transfer_done = done_reg;
    assign m_final_result  = final_reg;

endmodule

`default_nettype wire

>>> rtl/tftp_data_receiver_unit.sv
// TFTP data receiver top level: parser front end, entry queue, result issue.
// Depends on tdr_pkg, tdr_front, tdr_queue, tdr_back.
//
// Takes one TFTP payload byte per cycle whenever the four-entry queue between
// the parser and the issue stage has room. Each DATA byte of a matching block,
// up to 1024 per packet, yields a memory-write transfer; the final byte of a
// matching packet also yields an ack transfer, so a final byte that also
// carries data yields a write and then an ack. Output is one transfer per cycle
// while m_ready is high, from a registered stage. download_base must be written
// through the cfg channel only while the block is idle; the block itself does
// not enforce this. The start address follows via base_reg and block_addr_reg.
`default_nettype none

module tftp_data_receiver_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_payload_byte,
    input  wire logic        s_packet_end,
    input  wire logic [15:0] s_sender_port,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic [31:0]      m_write_address,
    output logic [7:0]       m_write_data,
    output logic [15:0]      m_ack_block,
    output logic [15:0]      m_ack_port,
    output logic             m_transfer_done,
    output logic             m_final_result
);

    logic                   push_valid;
    logic                   push_ready;
    tdr_pkg::tdr_entry_t    push_entry;
    logic                   pop_valid;
    logic                   pop;
    tdr_pkg::tdr_entry_t    pop_entry;

    assign cfg_ready = 1'b1;

    tdr_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_packet_end   (s_packet_end),
        .s_sender_port  (s_sender_port),
        .push_valid     (push_valid),
        .push_entry     (push_entry),
        .push_ready     (push_ready)
    );

    tdr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop        (pop)
    );

    tdr_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop_valid       (pop_valid),
        .pop_entry       (pop_entry),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_write_address (m_write_address),
        .m_write_data    (m_write_data),
        .m_ack_block     (m_ack_block),
        .m_ack_port      (m_ack_port),
        .m_transfer_done (m_transfer_done),
        .m_final_result  (m_final_result)
    );

endmodule

`default_nettype wire

>>> sim/tdr_checker.sv
// Checker for tftp_data_receiver_unit: watches the cfg, s_ and m_ channels,
// predicts every output transfer and compares it field by field.
// Depends on tdr_pkg.
module tdr_checker
    import tdr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_payload_byte,
    input  wire logic        s_packet_end,
    input  wire logic [15:0] s_sender_port,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_kind,
    input  wire logic [31:0] m_write_address,
    input  wire logic [7:0]  m_write_data,
    input  wire logic [15:0] m_ack_block,
    input  wire logic [15:0] m_ack_port,
    input  wire logic        m_transfer_done,
    input  wire logic        m_final_result,
    output int               fail_count,
    output int               pending,
    output int               write_count,
    output int               ack_count,
    output int               done_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        kind;
        logic [31:0] addr;
        logic [7:0]  data;
        logic [15:0] blk;
        logic [15:0] port;
        logic        done;
        logic        fin;
    } xfer_t;

    xfer_t expected_xfers[$];

    logic [31:0]        dl_base;
    logic [2:0]         hdr_pos;
    logic [15:0]        rx_opcode;
    logic [15:0]        rx_block;
    logic [15:0]        next_block;
    logic [COUNT_W-1:0] rx_data_cnt;

    int errs   = 0;
    int n_wr   = 0;
    int n_ack  = 0;
    int n_done = 0;

    initial begin
        fail_count  = 0;
        pending     = 0;
        write_count = 0;
        ack_count   = 0;
        done_count  = 0;
    end

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("tdr mismatch on %s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errs++;
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic is_end,
                                input logic [15:0] port);
        xfer_t x;
        logic  hit;
        int    n;
        n = 0;
        if (hdr_pos < HDR_LEN) begin
            if (hdr_pos < 3'd2) begin
                rx_opcode = {rx_opcode[7:0], b};
            end else begin
                rx_block = {rx_block[7:0], b};
            end
            hdr_pos = hdr_pos + 3'd1;
        end else if (rx_opcode == OPCODE_DATA && rx_block == next_block
                     && rx_data_cnt < MAX_DATA) begin
            x      = '0;
            x.kind = KIND_WRITE;
            x.addr = dl_base + (32'(next_block) - 32'd1) * 32'(BLOCK_SIZE)
                     + 32'(rx_data_cnt);
            x.data = b;
            expected_xfers.push_back(x);
            rx_data_cnt = rx_data_cnt + 1'b1;
            n++;
        end
        if (is_end) begin
            hit = hdr_pos == HDR_LEN && rx_opcode == OPCODE_DATA
                  && rx_block == next_block;
            if (hit) begin
                x      = '0;
                x.kind = KIND_ACK;
                x.blk  = rx_block;
                x.port = port;
                x.done = rx_data_cnt < BLOCK_SIZE;
                expected_xfers.push_back(x);
                n++;
                // short block ends the download
                next_block = x.done ? 16'd1 : next_block + 16'd1;
            end
            hdr_pos     = '0;
            rx_opcode   = '0;
            rx_block    = '0;
            rx_data_cnt = '0;
        end
        if (n > 0) begin
            expected_xfers[expected_xfers.size() - 1].fin = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        xfer_t want;
        if (!aresetn) begin
            expected_xfers.delete();
            dl_base     = '0;
            hdr_pos     = '0;
            rx_opcode   = '0;
            rx_block    = '0;
            next_block  = 16'd1;
            rx_data_cnt = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                dl_base = cfg_data;
            end
            if (s_valid && s_ready) begin
                predict_byte(s_payload_byte, s_packet_end, s_sender_port);
            end
            if (m_valid && m_ready) begin
                if (expected_xfers.size() == 0) begin
                    $error("tdr unexpected transfer: kind %0d address 0x%0h block %0d",
                           m_kind, m_write_address, m_ack_block);
                    errs++;
                end else begin
                    want = expected_xfers.pop_front();
                    compare_field("kind", 32'(want.kind), 32'(m_kind));
                    compare_field("write_address", want.addr, m_write_address);
                    compare_field("write_data", 32'(want.data), 32'(m_write_data));
                    compare_field("ack_block", 32'(want.blk), 32'(m_ack_block));
                    compare_field("ack_port", 32'(want.port), 32'(m_ack_port));
                    compare_field("transfer_done", 32'(want.done), 32'(m_transfer_done));
                    compare_field("final_result", 32'(want.fin), 32'(m_final_result));
                    if (m_kind == KIND_ACK) begin
                        n_ack++;
                        if (m_transfer_done) begin
                            n_done++;
                        end
                    end else begin
                        n_wr++;
                    end
                end
            end
        end
        fail_count  <= errs;
        pending     <= expected_xfers.size();
        write_count <= n_wr;
        ack_count   <= n_ack;
        done_count  <= n_done;
    end

endmodule

>>> sim/tb_top.sv
// Testbench top for tftp_data_receiver_unit: clock, reset, cfg writes,
// TFTP packet stimulus with random gaps and output stalls, and the verdict.
// Depends on tdr_pkg, tdr_checker and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tdr_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_payload_byte;
    logic        s_packet_end;
    logic [15:0] s_sender_port;
    logic        m_valid;
    logic        m_ready;
    logic        m_kind;
    logic [31:0] m_write_address;
    logic [7:0]  m_write_data;
    logic [15:0] m_ack_block;
    logic [15:0] m_ack_port;
    logic        m_transfer_done;
    logic        m_final_result;

    int fail_count;
    int pending;
    int write_count;
    int ack_count;
    int done_count;

    bit          in_gaps  = 1'b0;
    bit          out_gaps = 1'b0;
    logic [15:0] exp_blk  = 16'd1;
    int          good_bytes = 0;
    int          n_bytes    = 0;
    int          n_packets  = 0;

    tftp_data_receiver_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload_byte  (s_payload_byte),
        .s_packet_end    (s_packet_end),
        .s_sender_port   (s_sender_port),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_write_address (m_write_address),
        .m_write_data    (m_write_data),
        .m_ack_block     (m_ack_block),
        .m_ack_port      (m_ack_port),
        .m_transfer_done (m_transfer_done),
        .m_final_result  (m_final_result)
    );

    tdr_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload_byte  (s_payload_byte),
        .s_packet_end    (s_packet_end),
        .s_sender_port   (s_sender_port),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_write_address (m_write_address),
        .m_write_data    (m_write_data),
        .m_ack_block     (m_ack_block),
        .m_ack_port      (m_ack_port),
        .m_transfer_done (m_transfer_done),
        .m_final_result  (m_final_result),
        .fail_count      (fail_count),
        .pending         (pending),
        .write_count     (write_count),
        .ack_count       (ack_count),
        .done_count      (done_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // result side: random stalls per transfer
    initial begin
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = out_gaps ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic pick_idling();
        in_gaps  = $urandom_range(0, 3) != 0;
        out_gaps = $urandom_range(0, 3) != 0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic is_end,
                             input logic [15:0] port);
        int gap;
        gap = in_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_payload_byte <= b;
        s_packet_end   <= is_end;
        s_sender_port  <= port;
        do @(posedge aclk); while (!s_ready);
        n_bytes++;
        if (is_end) begin
            n_packets++;
        end
    endtask

    task automatic send_packet(input logic [15:0] opc, input logic [15:0] blk,
                               input int ndata, input logic [15:0] end_port);
        logic [7:0] b;
        int         total;
        pick_idling();
        total = ndata + 4;
        for (int i = 0; i < total; i++) begin
            case (i)
                0:       b = opc[15:8];
                1:       b = opc[7:0];
                2:       b = blk[15:8];
                3:       b = blk[7:0];
                default: b = 8'($urandom);
            endcase
            send_byte(b, i == total - 1, (i == total - 1) ? end_port : 16'($urandom));
        end
        if (opc == OPCODE_DATA && blk == exp_blk) begin
            exp_blk = (ndata < BLOCK_SIZE) ? 16'd1 : exp_blk + 16'd1;
            good_bytes += total;
        end
    endtask

    task automatic send_junk(input int len);
        pick_idling();
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom), i == len - 1, 16'($urandom));
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_base(input logic [31:0] base);
        cfg_valid <= 1'b1;
        cfg_data  <= base;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int target);
        int          start;
        int          r;
        int          len;
        logic [15:0] opc;
        start = good_bytes;
        while (good_bytes - start < target) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                len = $urandom_range(0, 40);
                send_packet(OPCODE_DATA, exp_blk, len, 16'($urandom));
            end else if (r < 75) begin
                send_packet(OPCODE_DATA, exp_blk + 16'($urandom_range(1, 65535)),
                            $urandom_range(0, 8), 16'($urandom));
            end else if (r < 85) begin
                opc = 16'($urandom);
                if (opc == OPCODE_DATA) begin
                    opc = opc ^ 16'h0100;
                end
                send_packet(opc, exp_blk, $urandom_range(0, 8), 16'($urandom));
            end else if (r < 93) begin
                send_junk($urandom_range(1, 3));
            end else begin
                send_junk($urandom_range(1, 12));
            end
        end
    endtask

    initial begin
        aresetn        <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        s_valid        <= 1'b0;
        s_payload_byte <= '0;
        s_packet_end   <= 1'b0;
        s_sender_port  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        write_base(32'h0000_0000);
        @(posedge aclk);
        // short packets, empty and small DATA blocks, wrong block, wrong opcode
        send_byte(8'hFF, 1'b1, 16'hFFFF);
        send_junk(3);
        send_packet(OPCODE_DATA, exp_blk, 0, 16'h0000);
        send_packet(OPCODE_DATA, exp_blk, 2, 16'hFFFF);
        send_packet(OPCODE_DATA, exp_blk + 16'd1, 1, 16'h1234);
        send_packet(16'hFF03, exp_blk, 1, 16'h4321);
        settle();

        // full block, oversize block, then empty closing block, addresses wrapping
        write_base(32'hFFFF_FFFF);
        @(posedge aclk);
        send_packet(OPCODE_DATA, exp_blk, BLOCK_SIZE, 16'($urandom));
        send_packet(OPCODE_DATA, exp_blk, MAX_DATA + 6, 16'($urandom));
        send_packet(OPCODE_DATA, exp_blk, 0, 16'($urandom));
        settle();

        write_base(32'($urandom));
        @(posedge aclk);
        run_random(12);
        settle();
        write_base(32'hFFFF_FC00);
        @(posedge aclk);
        run_random(12);
        settle();
        write_base(32'h8000_0000);
        @(posedge aclk);
        run_random(12);
        settle();
        write_base(32'h0000_0000);
        @(posedge aclk);
        run_random(12);
        settle();

        $display("Covered %0d input bytes in %0d packets over six base addresses.",
                 n_bytes, n_packets);
        $display("Checked %0d memory writes and %0d acks, %0d of them ending a download.",
                 write_count, ack_count, done_count);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/tdr_pkg.sv
rtl/tdr_front.sv
rtl/tdr_queue.sv
rtl/tdr_back.sv
rtl/tftp_data_receiver_unit.sv
sim/tdr_checker.sv
sim/tb_top.sv
